// ===== hdl/lru_page_frame_mapper_macros.svh =====
// ----------------------------------------------------------------------------
// lru page frame mapper assertion macros
// concurrent check helpers, all sampled on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_FRAME_MAPPER_MACROS_SVH
`define LRU_PAGE_FRAME_MAPPER_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression must hold at every clock edge
`define LPFM_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define LPFM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LPFM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LPFM_ASSERT_ALWAYS(label, expr, msg)
`define LPFM_ASSERT_SAME(label, ante, cons, msg)
`define LPFM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hdl/lpfm_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfm_pkg
// shared types and constants for the lru page frame mapper
// ----------------------------------------------------------------------------
package lpfm_pkg;

	// default geometry
	localparam int FRAMES_DEF     = 16;
	localparam int PAGE_BYTES_DEF = 4096;

	// field widths
	localparam int PAGE_W   = 32;
	localparam int OFFSET_W = 12;
	localparam int REQ_W    = 32;
	localparam int FRAME_W  = 4;
	localparam int ADDR_W   = 16;
	localparam int LEN_W    = 13;
	localparam int CFG_W    = 5;

	// reset value of frames_in_use
	localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

	// stream word widths, padded to whole bytes
	localparam int IN_BITS   = PAGE_W + OFFSET_W + REQ_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = FRAME_W + PAGE_W + ADDR_W + LEN_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_USER_W = 2;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_DONE
	} lpfm_state_t;

endpackage

// ===== hdl/lpfm_page_ram.sv =====
// ----------------------------------------------------------------------------
// lpfm_page_ram
// page number store, one write port and one registered read port
// ----------------------------------------------------------------------------
module lpfm_page_ram
	import lpfm_pkg::*;
#(
	parameter int DEPTH = FRAMES_DEF,
	parameter int AW    = $clog2(FRAMES_DEF)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [PAGE_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [PAGE_W-1:0] rdata
);

	logic [PAGE_W-1:0] mem_q [DEPTH];
	logic [PAGE_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/lru_page_frame_mapper.sv =====
// ----------------------------------------------------------------------------
// lru_page_frame_mapper
// fully associative page buffer with lru replacement and address mapping
// ----------------------------------------------------------------------------
// Each accepted word is one page access. The block scans the active frames
// one per cycle, reading the page store and the recency rank of that frame
// through a single compare unit; it stops at the lowest-numbered matching
// frame, or after the last active frame picks the least recently used one as
// victim. After acceptance, the first read is issued, the compares follow
// behind the registered page store read, then come one update step and the
// load of the output register. s_tready comes back together with the loaded
// result, so a new access is only taken once the previous one is through;
// the serial scan through the page store read port sets the access rate.
// s_tready is high only while no access is in progress. A finished result
// waits in the output register; the next access is still accepted and
// scanned, and holds in its last step until that register is free. The
// frames_in_use register may be written while idle.
// ----------------------------------------------------------------------------
`include "lru_page_frame_mapper_macros.svh"

module lru_page_frame_mapper
	import lpfm_pkg::*;
#(
	parameter int FRAMES     = FRAMES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel: frames_in_use
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data,
	// access words
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// page_number[31:0], page_offset[43:32], request_length[75:44], zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// result words
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// frame[3:0], writeback_page[35:4], byte_address[51:36], length[64:52], zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// hit[0], writeback[1]
	output logic [OUT_USER_W-1:0] m_tuser
);

	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = FW + 1;
	localparam int NW = (CW > CFG_W) ? CW : CFG_W;
	localparam int RW = $clog2(PAGE_BYTES + 1);
	localparam logic [FW-1:0] TOP_RANK = FW'(FRAMES - 1);

	lpfm_state_t state_q, state_d;

	// configuration
	logic [CFG_W-1:0] frames_in_use_q;
	logic [NW-1:0]    raw_ext;
	logic [NW-1:0]    n_val;
	logic [CW-1:0]    n_q;

	// captured access
	logic [PAGE_W-1:0]   page_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [REQ_W-1:0]    req_q;
	logic [RW-1:0]       room_q;
	logic [RW-1:0]       room_d;

	// per-frame state
	logic [FW-1:0]     rank_q [FRAMES];
	logic [FRAMES-1:0] valid_q;

	// scan pipeline
	logic [CW-1:0]     rd_cnt_q;
	logic [FW-1:0]     rd_addr;
	logic              issue;
	logic              vld_s1;
	logic [FW-1:0]     idx_s1;
	logic [FW-1:0]     rank_s1;
	logic              fvalid_s1;
	logic [PAGE_W-1:0] page_rd;

	// compare unit
	logic cmp;
	logic match;
	logic last;
	logic take;

	// scan results
	logic              hit_q;
	logic [FW-1:0]     hit_idx_q;
	logic [FW-1:0]     hit_rank_q;
	logic [FW-1:0]     best_idx_q;
	logic [FW-1:0]     best_rank_q;
	logic [PAGE_W-1:0] best_page_q;
	logic              best_fv_q;

	// update step
	logic [FW-1:0]     fsel;
	logic [FW-1:0]     old_rank;
	logic              ram_we;
	logic [FW-1:0]     f_q;
	logic              wb_q;
	logic [PAGE_W-1:0] wb_page_q;

	// result assembly
	logic [31:0]       addr_full;
	logic [REQ_W-1:0]  len_full;
	logic              out_free;
	logic              accept;
	logic              m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [OUT_USER_W-1:0] m_tuser_q;
	logic [FRAMES-1:0] top_vec;

	// configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= FRAMES_IN_USE_RST;
		end else if (cfg_valid && cfg_ready) begin
			frames_in_use_q <= cfg_data;
		end
	end

	// clamp active frame count to 1..FRAMES
	always_comb begin
		raw_ext = NW'(frames_in_use_q);
		if (raw_ext == '0) begin
			n_val = NW'(1);
		end else if (raw_ext > NW'(FRAMES)) begin
			n_val = NW'(FRAMES);
		end else begin
			n_val = raw_ext;
		end
	end

	// room left in the page after the offset
	always_comb begin
		if (32'(s_tdata[PAGE_W +: OFFSET_W]) < 32'(PAGE_BYTES)) begin
			room_d = RW'(32'(PAGE_BYTES) - 32'(s_tdata[PAGE_W +: OFFSET_W]));
		end else begin
			room_d = '0;
		end
	end

	// compare unit on the frame read back from the store
	assign cmp   = vld_s1 && (state_q == ST_SCAN);
	assign match = cmp && fvalid_s1 && (page_rd == page_q);
	assign last  = cmp && ({1'b0, idx_s1} == (n_q - CW'(1)));
	assign take  = (idx_s1 == '0) || (rank_s1 < best_rank_q);

	assign out_free = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		issue    = 1'b0;
		ram_we   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = (rd_cnt_q < n_q);
				if (match || last) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				ram_we  = !hit_q;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rd_addr = rd_cnt_q[FW-1:0];

	// access capture and read counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			if (accept) begin
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q   <= s_tdata[0 +: PAGE_W];
			offset_q <= s_tdata[PAGE_W +: OFFSET_W];
			req_q    <= s_tdata[PAGE_W + OFFSET_W +: REQ_W];
			room_q   <= room_d;
			n_q      <= CW'(n_val);
		end
		idx_s1    <= rd_addr;
		rank_s1   <= rank_q[rd_addr];
		fvalid_s1 <= valid_q[rd_addr];
	end

	// page store
	lpfm_page_ram #(
		.DEPTH(FRAMES),
		.AW   (FW)
	) u_page_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fsel),
		.wdata(page_q),
		.raddr(rd_addr),
		.rdata(page_rd)
	);

	// scan result tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (accept) begin
			hit_q <= 1'b0;
		end else if (match) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (match) begin
			hit_idx_q  <= idx_s1;
			hit_rank_q <= rank_s1;
		end
		if (cmp && take) begin
			best_idx_q  <= idx_s1;
			best_rank_q <= rank_s1;
			best_page_q <= page_rd;
			best_fv_q   <= fvalid_s1;
		end
	end

	// chosen frame and its rank before the update
	assign fsel     = hit_q ? hit_idx_q : best_idx_q;
	assign old_rank = hit_q ? hit_rank_q : best_rank_q;

	// recency and valid update, one step for all frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= FW'(i);
			end
		end else if (state_q == ST_UPDATE) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (FW'(i) == fsel) begin
					rank_q[i] <= TOP_RANK;
				end else if (rank_q[i] > old_rank) begin
					rank_q[i] <= rank_q[i] - FW'(1);
				end
			end
			if (!hit_q) begin
				valid_q[fsel] <= 1'b1;
			end
		end
	end

	// result fields of the chosen frame
	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			f_q       <= fsel;
			wb_q      <= !hit_q && best_fv_q;
			wb_page_q <= (!hit_q && best_fv_q) ? best_page_q : '0;
		end
	end

	assign addr_full = 32'(f_q) * 32'(PAGE_BYTES) + 32'(offset_q);
	assign len_full  = (req_q < REQ_W'(room_q)) ? req_q : REQ_W'(room_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata_q <= OUT_DATA_W'({LEN_W'(len_full), ADDR_W'(addr_full), wb_page_q,
				FRAME_W'(f_q)});
			m_tuser_q <= {wb_q, hit_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// exactly one frame holds the top rank
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			top_vec[i] = (rank_q[i] == TOP_RANK);
		end
	end

	`LPFM_ASSERT_ALWAYS(a_one_top_rank, $onehot(top_vec), "recency ranks lost the top rank")
	`LPFM_ASSERT_SAME(a_hit_no_wb, m_tvalid && m_tuser[0], !m_tuser[1], "hit with writeback")
	`LPFM_ASSERT_SAME(a_scan_in_range, cmp, {1'b0, idx_s1} < n_q, "scan beyond active frames")
	`LPFM_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "ready while access in progress")

endmodule
